// ----- sv/abe_pkg.sv -----
// ----------------------------------------------------------------------------
// abe_pkg: shared types and constants for the block ADPCM encoder
// Predictor table, frame geometry, state codes.
// ----------------------------------------------------------------------------
package abe_pkg;
	localparam int FrameLen = 28;
	localparam int NumPred = 5;
	localparam int FracBits = 12;
	localparam int IdxW = 5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD, ST_ANA_RD, ST_ANA, ST_SEL, ST_SHIFT,
		ST_PK_RD, ST_PK, ST_EMIT, ST_TERM
	} state_t;

	// Predictor coefficients in units of 1/64
	function automatic logic signed [7:0] coef0(input logic [2:0] p);
		case (p)
			3'd1: coef0 = -8'sd60;
			3'd2: coef0 = -8'sd115;
			3'd3: coef0 = -8'sd98;
			3'd4: coef0 = -8'sd122;
			default: coef0 = 8'sd0;
		endcase
	endfunction

	function automatic logic signed [7:0] coef1(input logic [2:0] p);
		case (p)
			3'd2: coef1 = 8'sd52;
			3'd3: coef1 = 8'sd55;
			3'd4: coef1 = 8'sd60;
			default: coef1 = 8'sd0;
		endcase
	endfunction

	function automatic logic signed [15:0] clamp_in(input logic signed [15:0] s);
		if (s > 16'sd30719) clamp_in = 16'sd30719;
		else if (s < -16'sd30720) clamp_in = -16'sd30720;
		else clamp_in = s;
	endfunction
endpackage

// ----- sv/abe_ram.sv -----
// ----------------------------------------------------------------------------
// abe_ram: single-port synchronous RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module abe_ram #(
	parameter int Width = 16,
	parameter int Depth = 28,
	parameter int AddrW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] addr,
	input  logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// Write or read the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- sv/adpcm_block_encoder_core.sv -----
// ----------------------------------------------------------------------------
// adpcm_block_encoder_core: 28-sample frames to 16-byte ADPCM blocks
//
// channel   | ports                                 | handshake
// input     | sample, end_of_stream                 | start & !busy
// result    | out_byte, block_last, stream_last     | strobe, one cycle
//
// A sample that does not close a frame leaves busy low. A closing sample
// holds busy for the frame pass: zero padding of the unused tail entry by
// entry, two to six sweeps of the sample RAM (up to five predictors, then
// a rerun of the winner that writes its residual rows), a shift step, 28
// quantizing steps of a read and three phases each, then 16 bytes, and 16
// more for a terminator block at end of stream. Reset clears all control
// and history state. The receiver cannot stall; bytes leave at one per
// cycle.
// ----------------------------------------------------------------------------
module adpcm_block_encoder_core import abe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] sample,
	input  logic               end_of_stream,
	output logic               strobe,
	output logic [7:0]         out_byte,
	output logic               block_last,
	output logic               stream_last
);
	state_t state_q, state_d;
	logic [IdxW-1:0] fill_q, idx_q, idx_rd;
	logic eos_q, partial_q, wr_pass_q;
	logic [2:0] pred_q, best_q;
	logic [3:0] shift_q;
	logic [1:0] ph_q;
	logic signed [15:0] h1_q, h2_q, ah1_q, ah2_q;
	logic [23:0] pk_q, minpk_q;
	logic signed [31:0] e1_q, e2_q;
	logic signed [47:0] t_s1;
	logic signed [15:0] d_s2;
	logic [7:0] hdr_q;
	logic [3:0] nib_q [FrameLen];
	logic [4:0] bcnt_q;

	// Sample RAM
	logic s_we;
	logic [IdxW-1:0] s_addr;
	logic [15:0] s_wd, s_rd;
	abe_ram #(.Width(16), .Depth(FrameLen), .AddrW(IdxW)) u_smp (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

	// Residual RAM, one row per sample
	logic r_we;
	logic [IdxW-1:0] r_addr;
	logic [25:0] r_wd, r_rd;
	abe_ram #(.Width(26), .Depth(FrameLen), .AddrW(IdxW)) u_res (
		.clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wd), .rdata(r_rd));

	logic acc;
	assign acc = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign idx_rd = (idx_q >= 5'(FrameLen)) ? '0 : idx_q;

	// Residual of current sample for current predictor
	logic signed [15:0] sc;
	logic signed [25:0] res;
	logic [23:0] ares;
	assign sc = clamp_in($signed(s_rd));
	assign res = 26'(sc) * 26'sd64 + 26'(coef0(pred_q)) * 26'(h1_q)
		+ 26'(coef1(pred_q)) * 26'(h2_q);
	assign ares = res[25] ? 24'(-res) : res[23:0];

	// Running best predictor
	logic take;
	logic [23:0] new_min;
	logic [2:0] new_best;
	assign take = (pred_q == 3'd0) || (pk_q < minpk_q);
	assign new_min = take ? pk_q : minpk_q;
	assign new_best = take ? pred_q : best_q;

	// Quantize step one: residual plus error feedback
	logic signed [39:0] m0, m1;
	logic signed [47:0] tq;
	assign m0 = coef0(best_q) * e1_q;
	assign m1 = coef1(best_q) * e2_q;
	assign tq = (48'($signed(r_rd)) <<< FracBits) + 48'(m0) + 48'(m1);

	// Quantize step two: scale, round and clamp
	logic signed [63:0] tsh, vt, dq;
	logic signed [15:0] dsat;
	always_comb begin
		tsh = 64'(t_s1) <<< shift_q;
		if (tsh < 0) vt = -((-tsh) >>> (FracBits + 6));
		else vt = tsh >>> (FracBits + 6);
		dq = ((vt + 64'sd2048) >>> 12) <<< 12;
		if (dq > 64'sd32767) dsat = 16'sh7fff;
		else if (dq < -64'sd32768) dsat = 16'sh8000;
		else dsat = dq[15:0];
	end

	// Quantize step three: new feedback error
	logic signed [63:0] qq, xx, ee;
	logic signed [31:0] ee_sat;
	always_comb begin
		qq = 64'(d_s2) >>> shift_q;
		xx = (qq <<< (FracBits + 6)) - 64'(t_s1);
		ee = (xx + 64'sd32) >>> 6;
		if (ee > 64'sd2147483647) ee_sat = 32'sh7fffffff;
		else if (ee < -64'sd2147483648) ee_sat = 32'sh80000000;
		else ee_sat = ee[31:0];
	end

	// Shift search on floor(peak/64)
	logic [3:0] shf;
	logic [17:0] mn2;
	always_comb begin
		logic done;
		mn2 = minpk_q[23:6];
		shf = 4'd12;
		done = 1'b0;
		for (int k = 0; k < 12; k++) begin
			if (!done && ((18'h4000 >> k) & (mn2 + (18'h4000 >> (k + 3)))) != 0) begin
				shf = 4'(k);
				done = 1'b1;
			end
		end
	end

	// Memory port steering
	always_comb begin
		s_we = 1'b0; s_addr = idx_rd; s_wd = '0;
		r_we = 1'b0; r_addr = idx_rd; r_wd = res;
		case (state_q)
			ST_IDLE: if (acc) begin
				s_we = 1'b1; s_addr = fill_q; s_wd = sample;
			end
			ST_PAD: s_we = 1'b1;
			ST_ANA: begin
				r_addr = idx_q - 5'd1;
				r_we = wr_pass_q;
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc && (end_of_stream || fill_q == 5'(FrameLen - 1))) begin
				state_d = (fill_q == 5'(FrameLen - 1)) ? ST_ANA_RD : ST_PAD;
			end
			ST_PAD: if (idx_q == 5'(FrameLen - 1)) state_d = ST_ANA_RD;
			ST_ANA_RD: state_d = ST_ANA;
			ST_ANA: if (idx_q == 5'(FrameLen)) state_d = ST_SEL;
			ST_SEL: state_d = wr_pass_q ? ST_SHIFT : ST_ANA_RD;
			ST_SHIFT: state_d = ST_PK_RD;
			ST_PK_RD: state_d = ST_PK;
			ST_PK: if (ph_q == 2'd2) begin
				state_d = (idx_q == 5'(FrameLen - 1)) ? ST_EMIT : ST_PK_RD;
			end
			ST_EMIT: if (bcnt_q == 5'd15) state_d = eos_q ? ST_TERM : ST_IDLE;
			ST_TERM: if (bcnt_q == 5'd15) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; idx_q <= '0; eos_q <= 1'b0; partial_q <= 1'b0;
			pred_q <= '0; best_q <= '0; shift_q <= '0; ph_q <= '0;
			h1_q <= '0; h2_q <= '0; ah1_q <= '0; ah2_q <= '0;
			pk_q <= '0; minpk_q <= '0; e1_q <= '0; e2_q <= '0;
			t_s1 <= '0; d_s2 <= '0;
			hdr_q <= '0; bcnt_q <= '0; wr_pass_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					fill_q <= fill_q + 5'd1;
					eos_q <= end_of_stream;
					partial_q <= fill_q != 5'(FrameLen - 1);
					idx_q <= (fill_q == 5'(FrameLen - 1)) ? 5'd0 : fill_q + 5'd1;
					pred_q <= '0; wr_pass_q <= 1'b0;
				end
				ST_PAD: begin
					idx_q <= (idx_q == 5'(FrameLen - 1)) ? 5'd0 : idx_q + 5'd1;
				end
				ST_ANA_RD: begin
					idx_q <= 5'd1; pk_q <= '0; h1_q <= ah1_q; h2_q <= ah2_q;
				end
				ST_ANA: begin
					if (ares > pk_q) pk_q <= ares;
					h2_q <= h1_q; h1_q <= sc;
					if (idx_q != 5'(FrameLen)) idx_q <= idx_q + 5'd1;
				end
				ST_SEL: begin
					idx_q <= '0;
					if (wr_pass_q) begin
						ah1_q <= h1_q; ah2_q <= h2_q;
					end else begin
						minpk_q <= new_min;
						if (new_min <= 24'd448) begin
							best_q <= '0; pred_q <= '0; wr_pass_q <= 1'b1;
						end else if (pred_q == 3'(NumPred - 1)) begin
							best_q <= new_best; pred_q <= new_best; wr_pass_q <= 1'b1;
						end else begin
							best_q <= new_best; pred_q <= pred_q + 3'd1;
						end
					end
				end
				ST_SHIFT: begin
					shift_q <= shf; idx_q <= '0; ph_q <= '0;
					hdr_q <= {1'b0, best_q, shf};
				end
				ST_PK: begin
					if (ph_q == 2'd0) begin
						t_s1 <= tq; ph_q <= 2'd1;
					end else if (ph_q == 2'd1) begin
						d_s2 <= dsat; ph_q <= 2'd2;
					end else begin
						e2_q <= e1_q; e1_q <= ee_sat;
						ph_q <= 2'd0;
						if (idx_q != 5'(FrameLen - 1)) idx_q <= idx_q + 5'd1;
						bcnt_q <= '0;
					end
				end
				ST_EMIT: begin
					if (bcnt_q == 5'd15) begin
						fill_q <= '0; bcnt_q <= '0;
					end else bcnt_q <= bcnt_q + 5'd1;
				end
				ST_TERM: begin
					if (bcnt_q == 5'd15) begin
						fill_q <= '0; ah1_q <= '0; ah2_q <= '0; bcnt_q <= '0;
						e1_q <= '0; e2_q <= '0; hdr_q <= '0;
					end else bcnt_q <= bcnt_q + 5'd1;
				end
				default: ;
			endcase
		end
	end

	// Capture the nibble of each quantizing step
	always_ff @(posedge clk) begin
		if (state_q == ST_PK && ph_q == 2'd2) nib_q[idx_q] <= d_s2[15:12];
	end

	// Output byte
	always_comb begin
		strobe = (state_q == ST_EMIT) || (state_q == ST_TERM);
		block_last = strobe && bcnt_q == 5'd15;
		stream_last = (state_q == ST_TERM) && bcnt_q == 5'd15;
		out_byte = '0;
		if (state_q == ST_EMIT) begin
			if (bcnt_q == 5'd0) out_byte = hdr_q;
			else if (bcnt_q == 5'd1) out_byte = {7'd0, eos_q && partial_q};
			else out_byte = {nib_q[{bcnt_q[3:0] - 4'd2, 1'b1}],
				nib_q[{bcnt_q[3:0] - 4'd2, 1'b0}]};
		end else if (state_q == ST_TERM) begin
			if (bcnt_q == 5'd0) out_byte = hdr_q;
			else if (bcnt_q == 5'd1) out_byte = 8'd7;
		end
	end
endmodule

// ----- sv/abe_checker.sv -----
// ----------------------------------------------------------------------------
// abe_checker: port-level checks for the block encoder
// Block framing and stream termination seen at the ports.
// ----------------------------------------------------------------------------
module abe_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic block_last,
	input logic stream_last
);
	// Terminator end implies block end
	a_sl: assert property (@(posedge clk) disable iff (!arst_n)
		stream_last |-> block_last && strobe) else $error("stream_last w/o block end");
	// Bytes only while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("strobe while idle");
	// block_last only on a strobe
	a_bl: assert property (@(posedge clk) disable iff (!arst_n)
		block_last |-> strobe) else $error("block_last w/o strobe");
	// No byte right after an accepted sample
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe) else $error("strobe right after accept");
endmodule

bind adpcm_block_encoder_core abe_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .block_last(block_last), .stream_last(stream_last));

// ----- tb/adpcm_block_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// adpcm_block_encoder_checker: byte-level scoreboard for the ADPCM encoder
// Watches accepted samples, predicts the encoded bytes of every block and
// terminator, and compares each strobed byte with the oldest prediction.
// ----------------------------------------------------------------------------
module adpcm_block_encoder_checker import abe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] sample,
	input  logic               end_of_stream,
	input  logic               strobe,
	input  logic [7:0]         out_byte,
	input  logic               block_last,
	input  logic               stream_last,
	output int                 fail_count,
	output int                 pending,
	output int                 bytes_seen
);
	typedef struct packed {
		logic [7:0] data;
		logic       blk_last;
		logic       strm_last;
	} enc_byte_t;

	enc_byte_t byte_q[$];

	// encoder model state
	logic signed [15:0] frame_buf [FrameLen];
	int                 fill;
	longint             hist1, hist2;
	longint             err1, err2;
	logic [7:0]         hdr_last;

	function automatic longint flr_shr(longint x, int k);
		if (x >= 0) return x >>> k;
		return -((-x + ((longint'(1) << k) - 1)) >>> k);
	endfunction

	function automatic longint trn_shr(longint x, int k);
		if (x >= 0) return x >>> k;
		return -((-x) >>> k);
	endfunction

	function automatic longint clampv(longint s);
		if (s > 30719) return 30719;
		if (s < -30720) return -30720;
		return s;
	endfunction

	function automatic longint c0_of(int p);
		case (p)
			1: return -60;
			2: return -115;
			3: return -98;
			4: return -122;
			default: return 0;
		endcase
	endfunction

	function automatic longint c1_of(int p);
		case (p)
			2: return 52;
			3: return 55;
			4: return 60;
			default: return 0;
		endcase
	endfunction

	function automatic void push_byte(logic [7:0] d, logic bl, logic sl);
		enc_byte_t b;
		b.data = d;
		b.blk_last = bl;
		b.strm_last = sl;
		byte_q.push_back(b);
	endfunction

	function automatic void model_clear();
		fill = 0;
		hist1 = 0;
		hist2 = 0;
		err1 = 0;
		err2 = 0;
		hdr_last = '0;
	endfunction

	// analysis, shift search, quantizing and packing of one frame
	function automatic void encode_frame(logic [7:0] flag);
		longint resid [NumPred][FrameLen];
		longint minpk, pk, h1, h2, s, r, a, t, v, d, q, x, e;
		longint min2, mask;
		int best, shift, p, j;
		logic [3:0] nib [FrameLen];
		minpk = 0;
		best = 0;
		for (p = 0; p < NumPred; p++) begin
			h1 = hist1;
			h2 = hist2;
			pk = 0;
			for (j = 0; j < FrameLen; j++) begin
				s = clampv(frame_buf[j]);
				r = 64 * s + c0_of(p) * h1 + c1_of(p) * h2;
				a = (r < 0) ? -r : r;
				resid[p][j] = r;
				if (a > pk) pk = a;
				h2 = h1;
				h1 = s;
			end
			if (p == 0 || pk < minpk) begin
				minpk = pk;
				best = p;
			end
			if (minpk <= 448) begin
				best = 0;
				break;
			end
		end
		hist1 = clampv(frame_buf[FrameLen-1]);
		hist2 = clampv(frame_buf[FrameLen-2]);
		min2 = minpk / 64;
		mask = 'h4000;
		shift = 0;
		while (shift < 12) begin
			if ((mask & (min2 + (mask >> 3))) != 0) break;
			shift++;
			mask = mask >> 1;
		end
		for (j = 0; j < FrameLen; j++) begin
			t = resid[best][j] * (longint'(1) << FracBits)
				+ c0_of(best) * err1 + c1_of(best) * err2;
			v = trn_shr(t * (longint'(1) << shift), FracBits + 6);
			d = flr_shr(v + 'h800, 12) * 4096;
			if (d > 32767) d = 32767;
			if (d < -32768) d = -32768;
			nib[j] = 4'(flr_shr(d, 12));
			q = flr_shr(d, shift);
			x = q * (longint'(1) << (FracBits + 6)) - t;
			e = flr_shr(x + 32, 6);
			if (e > 64'sd2147483647) e = 64'sd2147483647;
			if (e < -64'sd2147483648) e = -64'sd2147483648;
			err2 = err1;
			err1 = e;
		end
		hdr_last = {best[3:0], shift[3:0]};
		push_byte(hdr_last, 1'b0, 1'b0);
		push_byte(flag, 1'b0, 1'b0);
		for (j = 0; j < 14; j++)
			push_byte({nib[2*j+1], nib[2*j]}, j == 13, 1'b0);
	endfunction

	function automatic void predict_sample(logic signed [15:0] s, logic eos);
		logic partial;
		frame_buf[fill] = s;
		fill++;
		if (fill >= FrameLen || eos) begin
			partial = fill < FrameLen;
			for (int j = fill; j < FrameLen; j++) frame_buf[j] = '0;
			encode_frame((eos && partial) ? 8'd1 : 8'd0);
			fill = 0;
		end
		if (eos) begin
			push_byte(hdr_last, 1'b0, 1'b0);
			push_byte(8'd7, 1'b0, 1'b0);
			for (int j = 0; j < 14; j++) push_byte(8'd0, j == 13, j == 13);
			model_clear();
		end
	endfunction

	// compare result bytes, then feed the accepted sample transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			fail_count = 0;
			bytes_seen = 0;
			byte_q.delete();
			model_clear();
		end else begin
			if (strobe) begin
				bytes_seen++;
				if (byte_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected byte: expected none, actual %02h/%b/%b",
						$time, out_byte, block_last, stream_last);
				end else begin
					enc_byte_t exp_b;
					exp_b = byte_q.pop_front();
					if (exp_b.data !== out_byte || exp_b.blk_last !== block_last
						|| exp_b.strm_last !== stream_last) begin
						fail_count++;
						$display("%0t: byte mismatch: expected %02h/%b/%b, actual %02h/%b/%b",
							$time, exp_b.data, exp_b.blk_last, exp_b.strm_last,
							out_byte, block_last, stream_last);
					end
				end
			end
			if (start && !busy) predict_sample(sample, end_of_stream);
		end
		pending = byte_q.size();
	end
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the ADPCM block encoder
// Drives directed and random sample streams with varied sender gaps; the
// checker module predicts and compares every encoded byte.
// ----------------------------------------------------------------------------
module testbench import abe_pkg::*; ();

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [15:0] sample = '0;
	logic               end_of_stream = 1'b0;
	logic               busy, strobe, block_last, stream_last;
	logic [7:0]         out_byte;
	int                 fail_count, pending, bytes_seen;
	int                 cycle_count = 0;
	int                 gap_pct = 0;
	int                 streams = 0;
	int                 samples_sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	adpcm_block_encoder_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .end_of_stream(end_of_stream), .strobe(strobe),
		.out_byte(out_byte), .block_last(block_last), .stream_last(stream_last)
	);

	adpcm_block_encoder_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .end_of_stream(end_of_stream), .strobe(strobe),
		.out_byte(out_byte), .block_last(block_last), .stream_last(stream_last),
		.fail_count(fail_count), .pending(pending), .bytes_seen(bytes_seen)
	);

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// send one sample transaction, with a random gap first; busy is
	// checked at the falling edge, so start is high only at an accepting edge
	task automatic send_sample(input logic signed [15:0] s, input logic eos);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		while (busy) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		sample <= s;
		end_of_stream <= eos;
		@(negedge clk);
		samples_sent++;
		if (eos) streams++;
	endtask

	function automatic logic signed [15:0] rand_sample(int style, int k);
		case (style)
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(15)) - 8);
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'((k * 1500 + int'($urandom_range(400))) % 20000 - 10000);
		endcase
	endfunction

	// random stream of random length and content style
	task automatic send_stream(input int len);
		int style;
		style = int'($urandom_range(3));
		for (int k = 0; k < len; k++)
			send_sample(rand_sample(style, k), k == len - 1);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, clamped input, one-sample stream, full frame end
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sd3, 1'b0);
		send_sample(-16'sd30721, 1'b1);
		for (int k = 0; k < FrameLen; k++)
			send_sample((k % 2) ? 16'sh8000 : 16'sh7fff, k == FrameLen - 1);

		// random: three idling phases of at least 80 samples each
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 24 : (ph == 1) ? 63 : 0;
			for (int n = 0; n < 80; ) begin
				int len;
				len = ($urandom_range(3) == 0) ? FrameLen * int'($urandom_range(1, 2))
					: int'($urandom_range(1, 60));
				send_stream(len);
				n += len;
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d samples in %0d streams, %0d encoded bytes checked",
			samples_sent, streams, bytes_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
